>>> rtl/core/page_framebuffer_draw_engine_defines.svh
// Assertion macros for the page framebuffer draw engine.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PFDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfde assertion failed: same cycle");

`define PFDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfde assertion failed: next cycle");

`else

`define PFDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PFDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/pfde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfde_pkg;

  localparam int FB_BYTES  = 512;
  localparam int FB_ADDR_W = 9;

  localparam logic [2:0] ACT_FILL   = 3'd0;
  localparam logic [2:0] ACT_PIXEL  = 3'd1;
  localparam logic [2:0] ACT_BLIT   = 3'd2;
  localparam logic [2:0] ACT_BYTE   = 3'd3;
  localparam logic [2:0] ACT_GLYPH  = 3'd4;
  localparam logic [2:0] ACT_READ   = 3'd5;

  localparam logic [15:0] PIX_MSB = 16'h8000;
  localparam logic [7:0]  BYTE_ON = 8'hFF;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_FILL = 2'd1;
  localparam kind_t KIND_PIX  = 2'd2;
  localparam kind_t KIND_READ = 2'd3;

  typedef struct packed {
    logic capture;
    logic sweep_step;
    logic pix_advance;
    logic pix_write;
    logic read_issue;
    logic read_cap;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  sweep_last;
    logic  pix_last;
    logic  pix_hit;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/pfde_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/pfde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfde_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output logic                out_valid,
  output pfde_pkg::cmd_t      cmd,
  input  wire pfde_pkg::sts_t sts
);

  import pfde_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_PIX_RD = 3'd3;
  localparam logic [2:0] S_PIX_WR = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RCAP   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (sts.kind)
            KIND_FILL: state_nxt = S_FILL;
            KIND_PIX:  state_nxt = S_PIX_RD;
            KIND_READ: state_nxt = S_READ;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_PIX_RD: begin
        if (sts.pix_hit) begin
          state_nxt = S_PIX_WR;
        end else if (sts.pix_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pix_advance = 1'b1;
        end
      end
      S_PIX_WR: begin
        cmd.pix_write = 1'b1;
        if (sts.pix_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pix_advance = 1'b1;
          state_nxt       = S_PIX_RD;
        end
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
        state_nxt      = S_RCAP;
      end
      S_RCAP: begin
        cmd.read_cap = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

>>> rtl/core/pfde_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module pfde_dpath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     in_action,
  input  wire logic [7:0]     in_x,
  input  wire logic [7:0]     in_y,
  input  wire logic [7:0]     in_width,
  input  wire logic [5:0]     in_height,
  input  wire logic [15:0]    in_data,
  input  wire logic           in_color,
  input  wire logic           in_last,
  input  wire logic [8:0]     in_index,
  input  wire pfde_pkg::cmd_t cmd,
  output pfde_pkg::sts_t      sts,
  output logic [7:0]          out_read_data,
  output logic                out_accepted
);

  import pfde_pkg::*;

  localparam int PAGE_W = 5;
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int LIN_W  = PAGE_W + COL_W + 1;

  localparam logic [8:0]       W_LIM   = 9'(SCREEN_WIDTH);
  localparam logic [8:0]       H_LIM   = 9'(SCREEN_HEIGHT);
  localparam logic [LIN_W-1:0] W_MUL   = LIN_W'(SCREEN_WIDTH);
  localparam logic [LIN_W-1:0] LIN_LIM = LIN_W'(FB_BYTES);

  function automatic logic [LIN_W-1:0] lin_addr(input logic [7:0] ax, input logic [7:0] ay);
    return LIN_W'(ax) + LIN_W'(ay[7:3]) * W_MUL;
  endfunction

  function automatic logic in_bounds(input logic [7:0] ax, input logic [7:0] ay);
    return ({1'b0, ax} < W_LIM) && ({1'b0, ay} < H_LIM) && (lin_addr(ax, ay) < LIN_LIM);
  endfunction

  // drawing state
  logic [7:0] cursor_x_r, cursor_x_nxt;
  logic [7:0] cursor_y_r, cursor_y_nxt;
  logic [7:0] origin_x_r, origin_x_nxt;
  logic [7:0] blit_x_r, blit_x_nxt;
  logic [7:0] blit_y_r, blit_y_nxt;
  logic [4:0] row_cnt_r, row_cnt_nxt;
  logic [4:0] row_bytes_r, row_bytes_nxt;
  logic       blit_reject_r, blit_reject_nxt;
  logic [4:0] glyph_row_r, glyph_row_nxt;
  logic       glyph_reject_r, glyph_reject_nxt;
  logic [FB_ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [7:0] fill_byte_r, fill_byte_nxt;

  // pixel run and result
  logic [7:0]  base_x_r, base_x_nxt;
  logic [7:0]  pix_y_r, pix_y_nxt;
  logic [7:0]  cnt_n_r, cnt_n_nxt;
  logic [7:0]  j_r, j_nxt;
  logic [15:0] pat_r, pat_nxt;
  logic        on_r, on_nxt;
  logic        off_r, off_nxt;
  logic [8:0]  index_r, index_nxt;
  logic        acc_r, acc_nxt;
  logic [7:0]  rd_r, rd_nxt;

  logic [8:0] x_sum, y_sum, cx_sum, cy_sum, rb_full;
  logic       blit_bad, glyph_bad;
  logic [4:0] row_cnt_inc;
  logic [4:0] rb_sat;
  kind_t      cap_kind;

  logic [7:0]       px;
  logic [LIN_W-1:0] pix_lin;
  logic             white;
  logic [7:0]       bit_mask;
  logic [7:0]       ram_rdata;
  logic [7:0]       ram_wdata;
  logic [FB_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic             ram_we;

  assign x_sum       = {1'b0, in_x} + {1'b0, in_width};
  assign y_sum       = {1'b0, in_y} + 9'(in_height);
  assign cx_sum      = {1'b0, cursor_x_r} + {1'b0, in_width};
  assign cy_sum      = {1'b0, cursor_y_r} + 9'(in_height);
  assign blit_bad    = (x_sum > W_LIM) || (y_sum > H_LIM);
  assign glyph_bad   = (glyph_row_r == 5'd0) ? ((cx_sum > W_LIM) || (cy_sum > H_LIM))
                                             : glyph_reject_r;
  assign row_cnt_inc = row_cnt_r + 5'd1;
  assign rb_full     = ({1'b0, in_width} + 9'd4) >> 3;
  assign rb_sat      = (rb_full > 9'd31) ? 5'd31 : rb_full[4:0];

  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    origin_x_nxt     = origin_x_r;
    blit_x_nxt       = blit_x_r;
    blit_y_nxt       = blit_y_r;
    row_cnt_nxt      = row_cnt_r;
    row_bytes_nxt    = row_bytes_r;
    blit_reject_nxt  = blit_reject_r;
    glyph_row_nxt    = glyph_row_r;
    glyph_reject_nxt = glyph_reject_r;
    fill_byte_nxt    = fill_byte_r;
    base_x_nxt       = base_x_r;
    pix_y_nxt        = pix_y_r;
    cnt_n_nxt        = cnt_n_r;
    j_nxt            = j_r;
    pat_nxt          = pat_r;
    on_nxt           = on_r;
    off_nxt          = off_r;
    index_nxt        = index_r;
    acc_nxt          = acc_r;
    rd_nxt           = rd_r;
    sweep_cnt_nxt    = sweep_cnt_r;
    cap_kind         = KIND_NONE;

    unique case (in_action)
      ACT_FILL:  cap_kind = KIND_FILL;
      ACT_PIXEL: cap_kind = KIND_PIX;
      ACT_BYTE:  cap_kind = blit_reject_r ? KIND_NONE : KIND_PIX;
      ACT_GLYPH: cap_kind = (!glyph_bad && (in_width != 8'd0)) ? KIND_PIX : KIND_NONE;
      ACT_READ:  cap_kind = KIND_READ;
      default:   cap_kind = KIND_NONE;
    endcase

    if (cmd.capture) begin
      acc_nxt   = 1'b0;
      rd_nxt    = 8'd0;
      index_nxt = in_index;
      j_nxt     = 8'd0;
      unique case (in_action)
        ACT_FILL: begin
          fill_byte_nxt = in_color ? BYTE_ON : 8'd0;
          acc_nxt       = 1'b1;
        end
        ACT_PIXEL: begin
          base_x_nxt = in_x;
          pix_y_nxt  = in_y;
          cnt_n_nxt  = 8'd1;
          pat_nxt    = PIX_MSB;
          on_nxt     = in_color;
          off_nxt    = in_color;
          acc_nxt    = in_bounds(in_x, in_y);
        end
        ACT_BLIT: begin
          if (blit_bad) begin
            blit_reject_nxt = 1'b1;
          end else begin
            blit_reject_nxt = 1'b0;
            cursor_x_nxt    = in_x;
            cursor_y_nxt    = in_y;
            origin_x_nxt    = in_x;
            blit_x_nxt      = in_x;
            blit_y_nxt      = in_y;
            row_bytes_nxt   = rb_sat;
            row_cnt_nxt     = 5'd0;
            acc_nxt         = 1'b1;
          end
        end
        ACT_BYTE: begin
          if (!blit_reject_r) begin
            base_x_nxt = blit_x_r;
            pix_y_nxt  = blit_y_r;
            cnt_n_nxt  = 8'd8;
            pat_nxt    = {in_data[7:0], 8'd0};
            on_nxt     = 1'b1;
            off_nxt    = 1'b0;
            acc_nxt    = 1'b1;
            if (row_cnt_inc >= row_bytes_r) begin
              row_cnt_nxt = 5'd0;
              blit_y_nxt  = blit_y_r + 8'd1;
              blit_x_nxt  = origin_x_r;
            end else begin
              row_cnt_nxt = row_cnt_inc;
              blit_x_nxt  = blit_x_r + 8'd8;
            end
          end
        end
        ACT_GLYPH: begin
          glyph_reject_nxt = glyph_bad;
          base_x_nxt       = cursor_x_r;
          pix_y_nxt        = cursor_y_r + 8'(glyph_row_r);
          cnt_n_nxt        = in_width;
          pat_nxt          = in_data;
          on_nxt           = in_color;
          off_nxt          = ~in_color;
          acc_nxt          = ~glyph_bad;
          if (in_last) begin
            glyph_row_nxt = 5'd0;
            if (!glyph_bad) begin
              cursor_x_nxt = cursor_x_r + in_width;
            end
          end else begin
            glyph_row_nxt = glyph_row_r + 5'd1;
          end
        end
        ACT_READ: begin
          acc_nxt = 1'b1;
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.sweep_step) begin
      sweep_cnt_nxt = sweep_cnt_r + FB_ADDR_W'(1);
    end
    if (cmd.pix_advance) begin
      j_nxt   = j_r + 8'd1;
      pat_nxt = {pat_r[14:0], 1'b0};
    end
    if (cmd.read_cap) begin
      rd_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      origin_x_r     <= '0;
      blit_x_r       <= '0;
      blit_y_r       <= '0;
      row_cnt_r      <= '0;
      row_bytes_r    <= '0;
      blit_reject_r  <= 1'b1;
      glyph_row_r    <= '0;
      glyph_reject_r <= 1'b0;
      sweep_cnt_r    <= '0;
      fill_byte_r    <= '0;
    end else begin
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      origin_x_r     <= origin_x_nxt;
      blit_x_r       <= blit_x_nxt;
      blit_y_r       <= blit_y_nxt;
      row_cnt_r      <= row_cnt_nxt;
      row_bytes_r    <= row_bytes_nxt;
      blit_reject_r  <= blit_reject_nxt;
      glyph_row_r    <= glyph_row_nxt;
      glyph_reject_r <= glyph_reject_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
      fill_byte_r    <= fill_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_x_r <= base_x_nxt;
    pix_y_r  <= pix_y_nxt;
    cnt_n_r  <= cnt_n_nxt;
    j_r      <= j_nxt;
    pat_r    <= pat_nxt;
    on_r     <= on_nxt;
    off_r    <= off_nxt;
    index_r  <= index_nxt;
    acc_r    <= acc_nxt;
    rd_r     <= rd_nxt;
  end

  // current pixel of the run
  assign px       = base_x_r + j_r;
  assign pix_lin  = lin_addr(px, pix_y_r);
  assign white    = pat_r[15] ? on_r : off_r;
  assign bit_mask = 8'd1 << pix_y_r[2:0];

  assign ram_we    = cmd.sweep_step | cmd.pix_write;
  assign ram_waddr = cmd.sweep_step ? sweep_cnt_r : pix_lin[FB_ADDR_W-1:0];
  assign ram_wdata = cmd.sweep_step ? fill_byte_r
                   : (white ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));
  assign ram_raddr = cmd.read_issue ? index_r : pix_lin[FB_ADDR_W-1:0];

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_fb_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.kind       = cap_kind;
  assign sts.sweep_last = (sweep_cnt_r == FB_ADDR_W'(FB_BYTES - 1));
  assign sts.pix_last   = (j_r == (cnt_n_r - 8'd1));
  assign sts.pix_hit    = in_bounds(px, pix_y_r);

  assign out_read_data = rd_r;
  assign out_accepted  = acc_r;

endmodule

`default_nettype wire

>>> rtl/core/page_framebuffer_draw_engine.sv
// From accept to result strobe: a cursor/bitmap start, a rejected beat or an unused code goes
// straight to the result state; a read passes the read-issue and read-capture states.
// A pixel, bitmap byte or glyph row passes a read and a write state per drawn pixel
// (read-modify-write on the one framebuffer RAM) and only the read state per clipped pixel.
// Throughput: the next beat is accepted the cycle after the strobe; the receiver cannot stall.
// Fill sweeps 512 bytes. After reset the framebuffer is swept to zero with busy high.
`timescale 1ns / 1ps
`default_nettype none

`include "page_framebuffer_draw_engine_defines.svh"

module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_x,
  input  wire logic [7:0]  in_y,
  input  wire logic [7:0]  in_width,
  input  wire logic [5:0]  in_height,
  input  wire logic [15:0] in_data,
  input  wire logic        in_color,
  input  wire logic        in_last,
  input  wire logic [8:0]  in_index,
  output logic             out_valid,
  output logic [7:0]       out_read_data,
  output logic             out_accepted
);

  import pfde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pfde_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_width      (in_width),
    .in_height     (in_height),
    .in_data       (in_data),
    .in_color      (in_color),
    .in_last       (in_last),
    .in_index      (in_index),
    .cmd           (cmd),
    .sts           (sts),
    .out_read_data (out_read_data),
    .out_accepted  (out_accepted)
  );

  `PFDE_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, busy)
  `PFDE_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PFDE_ASSERT_NXT(a_single_beat, clk, rst_n, out_valid, !out_valid && !busy)
  `PFDE_ASSERT_IMP(a_read_acc, clk, rst_n, out_valid && (out_read_data != 8'd0), out_accepted)

endmodule

`default_nettype wire

>>> tb/page_framebuffer_draw_engine_tb.sv
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;
  import pfde_pkg::*;

  localparam int SCR_W = 128;
  localparam int SCR_H = 32;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int STEADY_FROM = 700;
  localparam int STEADY_TO   = 1000;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  width;
    logic [5:0]  height;
    logic [15:0] data;
    logic        color;
    logic        last;
    logic [8:0]  index;
    bit          drain;
    bit          steady;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       accepted;
  } draw_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_action = '0;
  logic [7:0]  in_x = '0;
  logic [7:0]  in_y = '0;
  logic [7:0]  in_width = '0;
  logic [5:0]  in_height = '0;
  logic [15:0] in_data = '0;
  logic        in_color = 1'b0;
  logic        in_last = 1'b0;
  logic [8:0]  in_index = '0;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic        out_accepted;

  draw_cmd_t   cmd_q[$];
  draw_reply_t due_q[$];
  bit          beat_taken = 1'b0;
  bit          failed = 1'b0;

  logic [7:0] fb_mirror [FB_BYTES] = '{default: 8'h00};
  logic [7:0] cur_x = '0;
  logic [7:0] cur_y = '0;
  logic [7:0] org_x = '0;
  logic [7:0] bx = '0;
  logic [7:0] by = '0;
  logic [4:0] row_cnt = '0;
  logic [4:0] row_len = '0;
  logic       blit_rej = 1'b1;
  logic [4:0] g_row = '0;
  logic       g_rej = 1'b0;

  page_framebuffer_draw_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_width     (in_width),
    .in_height    (in_height),
    .in_data      (in_data),
    .in_color     (in_color),
    .in_last      (in_last),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_read_data(out_read_data),
    .out_accepted (out_accepted)
  );

  always #2 clk = ~clk;

  function automatic bit plot_px(int unsigned px, int unsigned py, bit white);
    int unsigned addr;
    if (px >= SCR_W || py >= SCR_H) return 1'b0;
    addr = px + (py / 8) * SCR_W;
    if (addr >= FB_BYTES) return 1'b0;
    fb_mirror[addr][py % 8] = white;
    return 1'b1;
  endfunction

  function automatic draw_reply_t apply_action(draw_cmd_t c);
    draw_reply_t r;
    int unsigned j;
    int unsigned n;
    int unsigned py;
    bit pbit;
    r.read_data = '0;
    r.accepted = 1'b0;
    case (c.action)
      ACT_FILL: begin
        foreach (fb_mirror[i]) fb_mirror[i] = c.color ? BYTE_ON : 8'h00;
        r.accepted = 1'b1;
      end
      ACT_PIXEL: begin
        r.accepted = plot_px(int'(c.x), int'(c.y), c.color);
      end
      ACT_BLIT: begin
        if (int'(c.x) + int'(c.width) > SCR_W || int'(c.y) + int'(c.height) > SCR_H) begin
          blit_rej = 1'b1;
        end else begin
          blit_rej = 1'b0;
          cur_x = c.x;
          cur_y = c.y;
          org_x = c.x;
          bx = c.x;
          by = c.y;
          n = (int'(c.width) + 4) / 8;
          row_len = (n > 31) ? 5'd31 : n[4:0];
          row_cnt = '0;
          r.accepted = 1'b1;
        end
      end
      ACT_BYTE: begin
        if (!blit_rej) begin
          for (j = 0; j < 8; j++) begin
            void'(plot_px(int'(bx), int'(by), c.data[7 - j]));
            bx = bx + 8'd1;
          end
          row_cnt = row_cnt + 5'd1;
          if (row_cnt >= row_len) begin
            row_cnt = '0;
            by = by + 8'd1;
            bx = org_x;
          end
          r.accepted = 1'b1;
        end
      end
      ACT_GLYPH: begin
        if (g_row == 0)
          g_rej = (int'(cur_x) + int'(c.width) > SCR_W) ||
                  (int'(cur_y) + int'(c.height) > SCR_H);
        if (!g_rej) begin
          py = (int'(cur_y) + int'(g_row)) % 256;
          for (j = 0; j < c.width; j++) begin
            pbit = (j < 16) && (((c.data << j) & PIX_MSB) != 16'h0000);
            void'(plot_px((int'(cur_x) + j) % 256, py, pbit ? c.color : ~c.color));
          end
          r.accepted = 1'b1;
        end
        if (c.last) begin
          g_row = '0;
          if (r.accepted) cur_x = cur_x + c.width;
        end else begin
          g_row = g_row + 5'd1;
        end
      end
      ACT_READ: begin
        r.read_data = fb_mirror[c.index];
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic draw_cmd_t make_cmd(logic [2:0] act);
    draw_cmd_t c;
    c.action = act;
    c.x = 8'($urandom_range(0, 255));
    c.y = 8'($urandom_range(0, 255));
    c.width = 8'($urandom_range(0, 128));
    c.height = 6'($urandom_range(0, 32));
    c.data = 16'($urandom_range(0, 65535));
    c.color = 1'($urandom_range(0, 1));
    c.last = 1'($urandom_range(0, 1));
    c.index = 9'($urandom_range(0, 511));
    c.drain = 1'b0;
    c.steady = 1'b0;
    return c;
  endfunction

  function automatic int cur_y_guess();
    return $urandom_range(0, SCR_H - 1);
  endfunction

  task automatic queue_bitmap();
    draw_cmd_t c;
    int w;
    int h;
    int n;
    int at;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 128) : $urandom_range(1, 24);
    h = $urandom_range(1, 16);
    c = make_cmd(ACT_BLIT);
    c.width = 8'(w);
    c.height = 6'(h);
    if ($urandom_range(0, 9) != 0) begin
      c.x = 8'($urandom_range(0, SCR_W - w));
      c.y = 8'($urandom_range(0, SCR_H - h));
    end
    at = cmd_q.size();
    cmd_q.push_back(c);
    n = $urandom_range(1, 16);
    repeat (n) cmd_q.push_back(make_cmd(ACT_BYTE));
    repeat ($urandom_range(1, 3)) begin
      c = make_cmd(ACT_READ);
      c.index = 9'((int'(cmd_q[at].x) + (int'(cmd_q[at].y) / 8) * SCR_W +
                    $urandom_range(0, 15)) % FB_BYTES);
      cmd_q.push_back(c);
    end
  endtask

  task automatic queue_glyph();
    draw_cmd_t c;
    int gw;
    int gh;
    int rows;
    bit col;
    if ($urandom_range(0, 1) == 0) begin
      c = make_cmd(ACT_BLIT);
      c.x = 8'($urandom_range(0, 120));
      c.y = 8'($urandom_range(0, 31));
      c.width = 8'($urandom_range(0, SCR_W - c.x));
      c.height = 6'($urandom_range(0, SCR_H - c.y));
      cmd_q.push_back(c);
    end
    gw = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 128) : $urandom_range(0, 16);
    gh = $urandom_range(1, 16);
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : gh;
    col = 1'($urandom_range(0, 1));
    for (int r = 0; r < rows; r++) begin
      c = make_cmd(ACT_GLYPH);
      c.width = 8'(gw);
      c.height = 6'(gh);
      c.color = col;
      c.last = (r == rows - 1) && ($urandom_range(0, 9) != 0);
      cmd_q.push_back(c);
    end
    repeat ($urandom_range(1, 3)) begin
      c = make_cmd(ACT_READ);
      c.index = 9'((cur_y_guess() / 8) * SCR_W + $urandom_range(0, SCR_W - 1));
      cmd_q.push_back(c);
    end
  endtask

  always @(negedge clk) begin
    draw_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (cmd_q.size() != 0 && !(cmd_q[0].drain && due_q.size() != 0) &&
          (cmd_q[0].steady || $urandom_range(0, 99) >= 16)) begin
        nxt = cmd_q.pop_front();
        in_action <= nxt.action;
        in_x <= nxt.x;
        in_y <= nxt.y;
        in_width <= nxt.width;
        in_height <= nxt.height;
        in_data <= nxt.data;
        in_color <= nxt.color;
        in_last <= nxt.last;
        in_index <= nxt.index;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    draw_reply_t want;
    draw_cmd_t taken;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (due_q.size() == 0) begin
          $error("result strobe with no beat pending");
          failed = 1'b1;
        end else begin
          want = due_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data expected %0h actual %0h", want.read_data, out_read_data);
            failed = 1'b1;
          end
          if (out_accepted !== want.accepted) begin
            $error("accepted expected %0b actual %0b", want.accepted, out_accepted);
            failed = 1'b1;
          end
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        taken.action = in_action;
        taken.x = in_x;
        taken.y = in_y;
        taken.width = in_width;
        taken.height = in_height;
        taken.data = in_data;
        taken.color = in_color;
        taken.last = in_last;
        taken.index = in_index;
        taken.drain = 1'b0;
        taken.steady = 1'b0;
        due_q.push_back(apply_action(taken));
      end
    end
  end

  initial begin
    draw_cmd_t c;
    int pick;

    c = make_cmd(ACT_BYTE); c.data = 16'h00FF; cmd_q.push_back(c);
    c = make_cmd(ACT_GLYPH); c.width = 16; c.height = 8; c.data = 16'h8001;
    c.color = 1'b1; c.last = 1'b0; cmd_q.push_back(c);
    c = make_cmd(ACT_GLYPH); c.width = 16; c.height = 8; c.data = 16'hFFFF;
    c.color = 1'b0; c.last = 1'b1; cmd_q.push_back(c);
    c = make_cmd(ACT_READ); c.index = 9'd0; cmd_q.push_back(c);
    c = make_cmd(ACT_PIXEL); c.x = 8'd127; c.y = 8'd31; c.color = 1'b1; cmd_q.push_back(c);
    c = make_cmd(ACT_READ); c.index = 9'd511; cmd_q.push_back(c);
    c = make_cmd(ACT_PIXEL); c.x = 8'd128; c.y = 8'd0; cmd_q.push_back(c);
    c = make_cmd(ACT_PIXEL); c.x = 8'd0; c.y = 8'd32; cmd_q.push_back(c);
    c = make_cmd(ACT_PIXEL); c.x = 8'd255; c.y = 8'd255; cmd_q.push_back(c);
    c = make_cmd(ACT_FILL); c.color = 1'b1; cmd_q.push_back(c);
    c = make_cmd(ACT_READ); c.index = 9'h155; cmd_q.push_back(c);
    c = make_cmd(ACT_BLIT); c.x = 8'd120; c.y = 8'd0; c.width = 8'd16; c.height = 6'd8;
    cmd_q.push_back(c);
    c = make_cmd(ACT_BYTE); cmd_q.push_back(c);
    c = make_cmd(ACT_BLIT); c.x = 8'd0; c.y = 8'd0; c.width = 8'd3; c.height = 6'd32;
    cmd_q.push_back(c);
    c = make_cmd(ACT_BYTE); c.data = 16'h00A5; cmd_q.push_back(c);
    c = make_cmd(ACT_BLIT); c.x = 8'd0; c.y = 8'd24; c.width = 8'd128; c.height = 6'd8;
    cmd_q.push_back(c);
    c = make_cmd(ACT_BYTE); c.data = 16'h005A; c.drain = 1'b1; cmd_q.push_back(c);
    c = make_cmd(ACT_GLYPH); c.width = 8'd20; c.height = 6'd8; c.color = 1'b0;
    c.last = 1'b1; cmd_q.push_back(c);
    c = make_cmd(ACT_GLYPH); c.width = 8'd128; c.height = 6'd8; c.last = 1'b1;
    cmd_q.push_back(c);
    c = make_cmd(ACT_READ); c.index = 9'd401; cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(ACT_SPARE6));
    cmd_q.push_back(make_cmd(ACT_SPARE7));
    c = make_cmd(ACT_FILL); c.color = 1'b0; cmd_q.push_back(c);
    c = make_cmd(ACT_READ); c.index = 9'd0; cmd_q.push_back(c);

    while (cmd_q.size() < 1525) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_bitmap();
      end else if (pick < 40) begin
        queue_glyph();
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 6)) begin
          c = make_cmd(ACT_PIXEL);
          if ($urandom_range(0, 4) != 0) begin
            c.x = 8'($urandom_range(0, 135));
            c.y = 8'($urandom_range(0, 35));
          end
          cmd_q.push_back(c);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) cmd_q.push_back(make_cmd(ACT_READ));
      end else if (pick < 83) begin
        cmd_q.push_back(make_cmd(ACT_FILL));
      end else if (pick < 88) begin
        cmd_q.push_back(make_cmd($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7));
      end else begin
        cmd_q.push_back(make_cmd(3'($urandom_range(0, 7))));
      end
    end

    foreach (cmd_q[i]) begin
      if (i >= STEADY_FROM && i < STEADY_TO) cmd_q[i].steady = 1'b1;
      if (i > 25 && $urandom_range(0, 49) == 0) cmd_q[i].drain = 1'b1;
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start || due_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pfde_pkg.sv
rtl/core/pfde_ram.sv
rtl/core/pfde_ctrl.sv
rtl/core/pfde_dpath.sv
rtl/core/page_framebuffer_draw_engine.sv
tb/page_framebuffer_draw_engine_tb.sv
